// ----- sv/srr_pkg.sv -----
// ----------------------------------------------------------------------------
// srr_pkg: shared types and constants for the selective repeat receiver
// Command/status bundles between controller and datapath, FSM states.
// ----------------------------------------------------------------------------
package srr_pkg;

   localparam int SRR_SEQ_SPACE     = 14;
   localparam int SRR_PAYLOAD_BYTES = 20;
   localparam int SRR_PAY_W         = 8 * SRR_PAYLOAD_BYTES;

   // ack checksum offset and last buffered-slot count per packet (six slots)
   localparam logic [9:0] SRR_ACK_BASE   = 10'd960;
   localparam logic [2:0] SRR_RUN_LAST   = 3'd5;
   localparam logic [2:0] SRR_WIN_RESET  = 3'd6;

   // csr word index
   localparam logic SRR_REG_WINDOW = 1'b0;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUM,
      ST_CHECK,
      ST_ACK1,
      ST_ACK2,
      ST_DATA,
      ST_RUN
   } state_type;

   typedef struct packed {
      logic capture;
      logic sum;
      logic check;
      logic emit_ack;
      logic emit_pkt;
      logic emit_run;
      logic store;
      logic last;
   } cmd_type;

   typedef struct packed {
      logic drop;
      logic is_exp;
      logic dup;
      logic store;
      logic more;
      logic out_free;
   } stat_type;

endpackage

// ----- sv/srr_ram.sv -----
// ----------------------------------------------------------------------------
// srr_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module srr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/srr_ctrl.sv -----
// ----------------------------------------------------------------------------
// srr_ctrl: packet sequencing state machine
// Steps each packet through sum, check and result emission.
// ----------------------------------------------------------------------------
module srr_ctrl
   import srr_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_SUM;
            end
         end
         ST_SUM:   state_in = ST_CHECK;
         ST_CHECK: state_in = ST_ACK1;
         ST_ACK1: begin
            if (stat.drop) begin
               state_in = ST_IDLE;
            end else if (stat.out_free) begin
               if (stat.is_exp) begin
                  state_in = ST_DATA;
               end else if (stat.dup) begin
                  state_in = ST_ACK2;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_ACK2: begin
            if (stat.out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_DATA, ST_RUN: begin
            if (stat.out_free) begin
               state_in = stat.more ? ST_RUN : ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_stall = (state_ff != ST_IDLE);
      case (state_ff)
         ST_IDLE:  cmd.capture = req_valid;
         ST_SUM:   cmd.sum     = 1'b1;
         ST_CHECK: cmd.check   = 1'b1;
         ST_ACK1: begin
            if (!stat.drop && stat.out_free) begin
               cmd.emit_ack = 1'b1;
               cmd.store    = stat.store;
               cmd.last     = !(stat.is_exp || stat.dup);
            end
         end
         ST_ACK2: begin
            if (stat.out_free) begin
               cmd.emit_ack = 1'b1;
               cmd.last     = 1'b1;
            end
         end
         ST_DATA: begin
            if (stat.out_free) begin
               cmd.emit_pkt = 1'b1;
               cmd.last     = !stat.more;
            end
         end
         ST_RUN: begin
            if (stat.out_free) begin
               cmd.emit_run = 1'b1;
               cmd.last     = !stat.more;
            end
         end
         default: cmd = '0;
      endcase
   end

endmodule

// ----- sv/srr_dp.sv -----
// ----------------------------------------------------------------------------
// srr_dp: receiver datapath
// Packet capture, checksum, window test, reorder slots and result register.
// ----------------------------------------------------------------------------
module srr_dp
   import srr_pkg::*;
#(
   parameter int SEQ_SPACE = SRR_SEQ_SPACE
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output stat_type           stat,
   input  logic [2:0]         window_size,
   input  logic [7:0]         req_seq_number,
   input  logic [7:0]         req_ack_field,
   input  logic [15:0]        req_check_value,
   input  logic [63:0]        req_payload_low,
   input  logic [63:0]        req_payload_mid,
   input  logic [31:0]        req_payload_high,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_result_kind,
   output logic [3:0]         rsp_ack_number,
   output logic [9:0]         rsp_ack_check,
   output logic [63:0]        rsp_out_payload_low,
   output logic [63:0]        rsp_out_payload_mid,
   output logic [31:0]        rsp_out_payload_high,
   output logic               rsp_last_of_run
);

   localparam int SEQ_W = $clog2(SEQ_SPACE);
   localparam int DW    = SEQ_W + 1;
   localparam int HALF  = SEQ_SPACE / 2;

   function automatic logic [10:0] byte_sum8(input logic [63:0] w);
      logic [10:0] s;
      s = '0;
      for (int k = 0; k < 8; k++) begin
         s = s + 11'(w[8*k +: 8]);
      end
      return s;
   endfunction

   function automatic logic [9:0] byte_sum4(input logic [31:0] w);
      logic [9:0] s;
      s = '0;
      for (int k = 0; k < 4; k++) begin
         s = s + 10'(w[8*k +: 8]);
      end
      return s;
   endfunction

   // captured packet
   logic [7:0]           seq_ff, seq_in;
   logic [7:0]           ack_ff, ack_in;
   logic [15:0]          chk_ff, chk_in;
   logic [SRR_PAY_W-1:0] pay_ff, pay_in;

   // partial byte sums
   logic [10:0] sum_lo_ff, sum_lo_in;
   logic [10:0] sum_mid_ff, sum_mid_in;
   logic [9:0]  sum_hi_ff, sum_hi_in;

   // classification
   logic drop_ff, drop_in;
   logic is_exp_ff, is_exp_in;
   logic dup_ff, dup_in;
   logic store_ff, store_in;

   // window state
   logic [SEQ_W-1:0]     exp_ff, exp_in;
   logic [SEQ_SPACE-1:0] full_ff, full_in;
   logic [2:0]           run_cnt_ff, run_cnt_in;

   // result register
   logic                 valid_ff, valid_in;
   logic                 kind_ff, kind_in;
   logic [3:0]           num_ff, num_in;
   logic [9:0]           achk_ff, achk_in;
   logic [SRR_PAY_W-1:0] out_ff, out_in;
   logic                 last_ff, last_in;

   logic [SRR_PAY_W-1:0] rd_data;
   logic [SEQ_W-1:0]     seq_idx;
   logic [SEQ_W-1:0]     exp_inc;
   logic [16:0]          total;
   logic                 sum_ok;
   logic                 in_space;
   logic [DW-1:0]        win;
   logic [DW-1:0]        seq_dist;
   logic                 in_win;
   logic                 old_seq;
   logic                 out_free;
   logic                 load;

   assign seq_idx  = seq_ff[SEQ_W-1:0];
   assign exp_inc  = (exp_ff == SEQ_W'(SEQ_SPACE - 1)) ? '0 : exp_ff + 1'b1;
   assign out_free = !valid_ff || !rsp_stall;
   assign load     = cmd.emit_ack || cmd.emit_pkt || cmd.emit_run;

   // checksum and window test on registered partial sums
   always_comb begin
      total = 17'(seq_ff) + {{9{ack_ff[7]}}, ack_ff} + 17'(sum_lo_ff)
            + 17'(sum_mid_ff) + 17'(sum_hi_ff);
      sum_ok   = (total == {chk_ff[15], chk_ff});
      in_space = (seq_ff < 8'(SEQ_SPACE));
      win      = (DW'(window_size) > DW'(HALF)) ? DW'(HALF) : DW'(window_size);
      if (seq_idx >= exp_ff) begin
         seq_dist = DW'(seq_idx) - DW'(exp_ff);
      end else begin
         seq_dist = DW'(seq_idx) + DW'(SEQ_SPACE) - DW'(exp_ff);
      end
      in_win  = (seq_dist < win);
      old_seq = (win != '0) && (seq_dist >= DW'(SEQ_SPACE) - win);
   end

   always_comb begin
      seq_in     = seq_ff;
      ack_in     = ack_ff;
      chk_in     = chk_ff;
      pay_in     = pay_ff;
      sum_lo_in  = sum_lo_ff;
      sum_mid_in = sum_mid_ff;
      sum_hi_in  = sum_hi_ff;
      drop_in    = drop_ff;
      is_exp_in  = is_exp_ff;
      dup_in     = dup_ff;
      store_in   = store_ff;
      exp_in     = exp_ff;
      full_in    = full_ff;
      run_cnt_in = run_cnt_ff;

      if (cmd.capture) begin
         seq_in = req_seq_number;
         ack_in = req_ack_field;
         chk_in = req_check_value;
         pay_in = {req_payload_high, req_payload_mid, req_payload_low};
      end
      if (cmd.sum) begin
         sum_lo_in  = byte_sum8(pay_ff[63:0]);
         sum_mid_in = byte_sum8(pay_ff[127:64]);
         sum_hi_in  = byte_sum4(pay_ff[159:128]);
      end
      if (cmd.check) begin
         drop_in    = !sum_ok || !in_space || (!in_win && !old_seq);
         is_exp_in  = in_win && (seq_dist == '0);
         dup_in     = in_win && (seq_dist != '0) && full_ff[seq_idx];
         store_in   = in_win && (seq_dist != '0) && !full_ff[seq_idx];
         run_cnt_in = '0;
      end
      if (cmd.store) begin
         full_in[seq_idx] = 1'b1;
      end
      if (cmd.emit_pkt) begin
         exp_in = exp_inc;
      end
      if (cmd.emit_run) begin
         full_in[exp_ff] = 1'b0;
         exp_in          = exp_inc;
         run_cnt_in      = run_cnt_ff + 1'b1;
      end
   end

   // result register
   always_comb begin
      valid_in = valid_ff && rsp_stall;
      kind_in  = kind_ff;
      num_in   = num_ff;
      achk_in  = achk_ff;
      out_in   = out_ff;
      last_in  = last_ff;
      if (load) begin
         valid_in = 1'b1;
         last_in  = cmd.last;
         kind_in  = !cmd.emit_ack;
         num_in   = '0;
         achk_in  = '0;
         out_in   = '0;
         if (cmd.emit_ack) begin
            num_in  = 4'(seq_idx);
            achk_in = SRR_ACK_BASE + 10'(seq_idx);
         end else if (cmd.emit_pkt) begin
            out_in = pay_ff;
         end else begin
            out_in = rd_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         drop_ff    <= 1'b1;
         is_exp_ff  <= 1'b0;
         dup_ff     <= 1'b0;
         store_ff   <= 1'b0;
         exp_ff     <= '0;
         full_ff    <= '0;
         run_cnt_ff <= '0;
         valid_ff   <= 1'b0;
      end else begin
         drop_ff    <= drop_in;
         is_exp_ff  <= is_exp_in;
         dup_ff     <= dup_in;
         store_ff   <= store_in;
         exp_ff     <= exp_in;
         full_ff    <= full_in;
         run_cnt_ff <= run_cnt_in;
         valid_ff   <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      seq_ff     <= seq_in;
      ack_ff     <= ack_in;
      chk_ff     <= chk_in;
      pay_ff     <= pay_in;
      sum_lo_ff  <= sum_lo_in;
      sum_mid_ff <= sum_mid_in;
      sum_hi_ff  <= sum_hi_in;
      kind_ff    <= kind_in;
      num_ff     <= num_in;
      achk_ff    <= achk_in;
      out_ff     <= out_in;
      last_ff    <= last_in;
   end

   // reorder slots; read address tracks the next expected pointer so the
   // read data always belongs to exp_ff
   srr_ram #(
      .WIDTH (SRR_PAY_W),
      .DEPTH (SEQ_SPACE)
   ) u_slots (
      .clock   (clock),
      .wr_en   (cmd.store),
      .wr_addr (seq_idx),
      .wr_data (pay_ff),
      .rd_addr (exp_in),
      .rd_data (rd_data)
   );

   always_comb begin
      stat.drop     = drop_ff;
      stat.is_exp   = is_exp_ff;
      stat.dup      = dup_ff;
      stat.store    = store_ff;
      stat.more     = full_ff[exp_inc] && (run_cnt_ff != SRR_RUN_LAST);
      stat.out_free = out_free;
   end

   assign rsp_valid            = valid_ff;
   assign rsp_result_kind      = kind_ff;
   assign rsp_ack_number       = num_ff;
   assign rsp_ack_check        = achk_ff;
   assign rsp_out_payload_low  = out_ff[63:0];
   assign rsp_out_payload_mid  = out_ff[127:64];
   assign rsp_out_payload_high = out_ff[159:128];
   assign rsp_last_of_run      = last_ff;

endmodule

// ----- sv/selective_repeat_receiver.sv -----
// ----------------------------------------------------------------------------
// selective_repeat_receiver: selective repeat ARQ receive side
// The first result is loaded in the ACK1 state, after the sum and check states.
// Per packet: capture, sum and check, then one emit state per result (1..8);
// a dropped packet leaves from ACK1 with no result.
// Next packet is taken once the last result is in the output register.
// Reset: synchronous; clears FSM, expected seq, slot flags, window to 6.
// ----------------------------------------------------------------------------
module selective_repeat_receiver
   import srr_pkg::*;
#(
   parameter int SEQ_SPACE = SRR_SEQ_SPACE
) (
   input  logic               clock,
   input  logic               reset,
   // packet in
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_seq_number,
   input  logic signed [7:0]  req_ack_field,
   input  logic signed [15:0] req_check_value,
   input  logic [63:0]        req_payload_low,
   input  logic [63:0]        req_payload_mid,
   input  logic [31:0]        req_payload_high,
   // results out
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_result_kind,
   output logic [3:0]         rsp_ack_number,
   output logic [9:0]         rsp_ack_check,
   output logic [63:0]        rsp_out_payload_low,
   output logic [63:0]        rsp_out_payload_mid,
   output logic [31:0]        rsp_out_payload_high,
   output logic               rsp_last_of_run,
   // config port
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   cmd_type  cmd;
   stat_type stat;

   // window_size register: word 0. Anything above half the sequence space
   // is clamped in the datapath, zero disables acceptance entirely.
   logic [2:0] window_ff, window_in;
   logic       csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && (paddr[2] == SRR_REG_WINDOW);

   always_comb begin
      window_in = window_ff;
      if (csr_wr) begin
         window_in = pwdata[2:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= SRR_WIN_RESET;
      end else begin
         window_ff <= window_in;
      end
   end

   assign prdata = (paddr[2] == SRR_REG_WINDOW) ? 32'(window_ff) : '0;

   // Controller: one packet at a time. Idle is the only state that takes a
   // transfer; each emit state waits for the output register to free up, so
   // a stalled result side simply holds the sequence in place.
   srr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Datapath: checksum is split into per-word byte sums then a final add
   // and compare; slot flags sit in flops, slot payloads in a RAM read at
   // the expected pointer. An in-order run delivers at most six buffered
   // packets, the rest stay for a later packet.
   srr_dp #(
      .SEQ_SPACE (SEQ_SPACE)
   ) u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .stat                 (stat),
      .window_size          (window_ff),
      .req_seq_number       (req_seq_number),
      .req_ack_field        (req_ack_field),
      .req_check_value      (req_check_value),
      .req_payload_low      (req_payload_low),
      .req_payload_mid      (req_payload_mid),
      .req_payload_high     (req_payload_high),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_result_kind      (rsp_result_kind),
      .rsp_ack_number       (rsp_ack_number),
      .rsp_ack_check        (rsp_ack_check),
      .rsp_out_payload_low  (rsp_out_payload_low),
      .rsp_out_payload_mid  (rsp_out_payload_mid),
      .rsp_out_payload_high (rsp_out_payload_high),
      .rsp_last_of_run      (rsp_last_of_run)
   );

endmodule

// ----- test/selective_repeat_receiver_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// selective_repeat_receiver_test: self-checking bench for the SR ARQ receiver
// Drives data packets and window settings, predicts every ACK and delivery
// transfer from a behavioral copy of the receive window, and compares each
// result transfer field by field, under random idling on both channels.
// ----------------------------------------------------------------------------
module selective_repeat_receiver_test
   import srr_pkg::*;
;

   localparam int         CYCLE_LIMIT  = 200000;
   localparam int         DRAIN_CYCLES = 20;     // covers the sum, check and ACK1 states of a dropped packet
   localparam logic [2:0] WINDOW_ADDR  = 3'(4 * SRR_REG_WINDOW);
   localparam logic [2:0] SPARE_ADDR   = 3'd4;   // no register here, writes must be ignored

   // one packet as presented on the request channel
   typedef struct {
      bit        [7:0]  seq;
      bit signed [7:0]  ack;
      bit signed [15:0] check;
      bit        [63:0] low;
      bit        [63:0] mid;
      bit        [31:0] high;
   } packet_type;

   // one transfer on the result channel
   typedef struct {
      logic        kind;
      logic [3:0]  ack_num;
      logic [9:0]  ack_chk;
      logic [63:0] low;
      logic [63:0] mid;
      logic [31:0] high;
      logic        last;
   } result_type;

   // -------------------------------------------------------------------------
   // Receive-window tracker: mirrors the expected sequence number, the
   // out-of-order buffer and the window register, and queues the ACK and
   // delivery transfers each accepted packet must produce.
   // -------------------------------------------------------------------------
   class arq_receive_tracker;
      localparam logic KIND_ACK  = 1'b0;
      localparam logic KIND_DATA = 1'b1;
      localparam int   RUN_MAX   = 6;   // buffered packets released per packet

      bit   [2:0]  window;
      int          expect_seq;
      bit          buffered [SRR_SEQ_SPACE];
      bit   [63:0] buf_low  [SRR_SEQ_SPACE];
      bit   [63:0] buf_mid  [SRR_SEQ_SPACE];
      bit   [31:0] buf_high [SRR_SEQ_SPACE];
      result_type  pending_results[$];
      int          errors;

      function new();
         window     = SRR_WIN_RESET;
         expect_seq = 0;
         errors     = 0;
         foreach (buffered[i]) buffered[i] = 1'b0;
      endfunction

      // bytes count as unsigned 0..255
      static function int payload_sum(bit [63:0] low, bit [63:0] mid, bit [31:0] high);
         int total;
         total = 0;
         for (int k = 0; k < 8; k++) total += int'(low[8*k +: 8]) + int'(mid[8*k +: 8]);
         for (int k = 0; k < 4; k++) total += int'(high[8*k +: 8]);
         return total;
      endfunction

      function result_type ack_of(int num);
         result_type r;
         r.kind    = KIND_ACK;
         r.ack_num = num[3:0];
         r.ack_chk = SRR_ACK_BASE + 10'(num);
         r.low     = '0;
         r.mid     = '0;
         r.high    = '0;
         r.last    = 1'b0;
         return r;
      endfunction

      function result_type delivery(bit [63:0] low, bit [63:0] mid, bit [31:0] high);
         result_type r;
         r.kind    = KIND_DATA;
         r.ack_num = '0;
         r.ack_chk = '0;
         r.low     = low;
         r.mid     = mid;
         r.high    = high;
         r.last    = 1'b0;
         return r;
      endfunction

      function void report(string what);
         if (errors < 10) $display("[%0t] %s", $time, what);
         errors++;
      endfunction

      function int pending();
         return pending_results.size();
      endfunction

      // called on every accepted request transfer
      function void take_packet(packet_type p);
         result_type burst[$];
         int         total;
         int         win;
         int         slot;
         int         seq_dist;
         int         count;
         total = int'(p.seq) + int'(p.ack) + payload_sum(p.low, p.mid, p.high);
         if (total != int'(p.check) || p.seq >= SRR_SEQ_SPACE) return;
         win  = (window > SRR_SEQ_SPACE / 2) ? SRR_SEQ_SPACE / 2 : int'(window);
         slot = int'(p.seq);
         seq_dist = (slot + SRR_SEQ_SPACE - expect_seq) % SRR_SEQ_SPACE;
         if (seq_dist < win) begin
            burst.push_back(ack_of(slot));
            if (seq_dist == 0) begin
               // in order: deliver, then release what now follows
               burst.push_back(delivery(p.low, p.mid, p.high));
               expect_seq = (expect_seq + 1) % SRR_SEQ_SPACE;
               count = 0;
               while (buffered[expect_seq] && count < RUN_MAX) begin
                  burst.push_back(delivery(buf_low[expect_seq], buf_mid[expect_seq],
                                           buf_high[expect_seq]));
                  buffered[expect_seq] = 1'b0;
                  expect_seq = (expect_seq + 1) % SRR_SEQ_SPACE;
                  count++;
               end
            end else if (!buffered[slot]) begin
               buffered[slot] = 1'b1;
               buf_low[slot]  = p.low;
               buf_mid[slot]  = p.mid;
               buf_high[slot] = p.high;
            end else begin
               burst.push_back(ack_of(slot));   // already held: second ACK
            end
         end else if (win > 0 && seq_dist >= SRR_SEQ_SPACE - win) begin
            burst.push_back(ack_of(slot));      // old packet, its ACK was lost
         end
         if (burst.size() == 0) return;
         burst[burst.size() - 1].last = 1'b1;
         foreach (burst[i]) pending_results.push_back(burst[i]);
      endfunction

      // called on every accepted result transfer
      function void check_result(result_type got);
         result_type want;
         if (pending_results.size() == 0) begin
            report($sformatf("unexpected result: kind=%0d ack=%0d chk=%0d last=%0d",
                             got.kind, got.ack_num, got.ack_chk, got.last));
            return;
         end
         want = pending_results.pop_front();
         if (got.kind !== want.kind || got.ack_num !== want.ack_num ||
             got.ack_chk !== want.ack_chk || got.low !== want.low ||
             got.mid !== want.mid || got.high !== want.high || got.last !== want.last)
            report($sformatf({"result mismatch\n  exp kind=%0d ack=%0d chk=%0d lo=%h",
                              " mid=%h hi=%h last=%0d\n  got kind=%0d ack=%0d chk=%0d",
                              " lo=%h mid=%h hi=%h last=%0d"},
                             want.kind, want.ack_num, want.ack_chk, want.low, want.mid,
                             want.high, want.last, got.kind, got.ack_num, got.ack_chk,
                             got.low, got.mid, got.high, got.last));
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // DUT hookup
   // -------------------------------------------------------------------------
   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [7:0]         req_seq_number;
   logic signed [7:0]  req_ack_field;
   logic signed [15:0] req_check_value;
   logic [63:0]        req_payload_low;
   logic [63:0]        req_payload_mid;
   logic [31:0]        req_payload_high;
   logic               rsp_valid;
   logic               rsp_stall;
   logic               rsp_result_kind;
   logic [3:0]         rsp_ack_number;
   logic [9:0]         rsp_ack_check;
   logic [63:0]        rsp_out_payload_low;
   logic [63:0]        rsp_out_payload_mid;
   logic [31:0]        rsp_out_payload_high;
   logic               rsp_last_of_run;
   logic               psel;
   logic               penable;
   logic               pwrite;
   logic [2:0]         paddr;
   logic [31:0]        pwdata;
   logic [31:0]        prdata;
   logic               pready;

   arq_receive_tracker tracker;
   int                 cycle_count   = 0;
   int                 send_idle_pct = 38;   // chance per cycle that the sender holds off
   int                 recv_idle_pct = 77;   // chance per cycle that the result side stalls

   selective_repeat_receiver i_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_seq_number       (req_seq_number),
      .req_ack_field        (req_ack_field),
      .req_check_value      (req_check_value),
      .req_payload_low      (req_payload_low),
      .req_payload_mid      (req_payload_mid),
      .req_payload_high     (req_payload_high),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_result_kind      (rsp_result_kind),
      .rsp_ack_number       (rsp_ack_number),
      .rsp_ack_check        (rsp_ack_check),
      .rsp_out_payload_low  (rsp_out_payload_low),
      .rsp_out_payload_mid  (rsp_out_payload_mid),
      .rsp_out_payload_high (rsp_out_payload_high),
      .rsp_last_of_run      (rsp_last_of_run),
      .psel                 (psel),
      .penable              (penable),
      .pwrite               (pwrite),
      .paddr                (paddr),
      .pwdata               (pwdata),
      .prdata               (prdata),
      .pready               (pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog: a hung handshake or a missing result ends here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // result side back-pressure, redrawn every cycle
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // result monitor: values read here are the ones present before the edge
   always @(posedge clock) begin
      result_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.kind    = rsp_result_kind;
         got.ack_num = rsp_ack_number;
         got.ack_chk = rsp_ack_check;
         got.low     = rsp_out_payload_low;
         got.mid     = rsp_out_payload_mid;
         got.high    = rsp_out_payload_high;
         got.last    = rsp_last_of_run;
         tracker.check_result(got);
      end
   end

   // -------------------------------------------------------------------------
   // stimulus helpers
   // -------------------------------------------------------------------------
   function automatic bit [63:0] rnd64();
      return {$urandom, $urandom};
   endfunction

   // packet with a correct checksum; the ack field counts as its signed byte
   function automatic packet_type make_packet(int seq, int ack, bit [63:0] low,
                                              bit [63:0] mid, bit [31:0] high);
      packet_type p;
      p.seq   = seq[7:0];
      p.ack   = ack[7:0];
      p.low   = low;
      p.mid   = mid;
      p.high  = high;
      p.check = 16'(int'(p.seq) + int'(p.ack)
                    + arq_receive_tracker::payload_sum(low, mid, high));
      return p;
   endfunction

   // Mostly well-formed traffic aimed around the current expected number:
   // in-order, inside the window, just behind it, plus stray and corrupt packets.
   function automatic packet_type random_packet();
      packet_type p;
      int         roll;
      int         pick;
      int         win;
      int         seq_dist;
      int         seq;
      int         ack;
      roll = $urandom_range(99);
      win  = tracker.window;
      if (roll < 70 && win > 0) begin
         pick = $urandom_range(99);
         if (pick < 25)
            seq_dist = 0;
         else if (pick < 65)
            seq_dist = $urandom_range(win - 1, 0);
         else if (pick < 85)
            seq_dist = SRR_SEQ_SPACE - $urandom_range(win, 1);
         else
            seq_dist = $urandom_range(SRR_SEQ_SPACE - 1, 0);
         seq = (tracker.expect_seq + seq_dist) % SRR_SEQ_SPACE;
      end else if ($urandom_range(1)) begin
         seq = $urandom_range(SRR_SEQ_SPACE - 1, 0);
      end else begin
         seq = $urandom_range(255, 0);
      end
      ack = $urandom_range(1) ? -1 : $urandom_range(255, 0);
      p   = make_packet(seq, ack, rnd64(), rnd64(), $urandom);
      if (roll >= 85) p.check = 16'($urandom);   // corrupt in transit
      return p;
   endfunction

   // one request transfer; valid stays up into the next packet when no gap is drawn
   task automatic send_packet(input packet_type p);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_seq_number   <= p.seq;
      req_ack_field    <= p.ack;
      req_check_value  <= p.check;
      req_payload_low  <= p.low;
      req_payload_mid  <= p.mid;
      req_payload_high <= p.high;
      do @(posedge clock); while (req_stall);
      tracker.take_packet(p);
   endtask

   // wait for every predicted result, then for a dropped packet to finish
   task automatic drain();
      req_valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic verify_window();
      logic [31:0] readback;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= WINDOW_ADDR;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      readback = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      if (readback !== 32'(tracker.window))
         tracker.report($sformatf("window readback: exp %0d got %h", tracker.window, readback));
   endtask

   // APB write (setup + access), then read the window back
   task automatic set_csr(input logic [2:0] addr, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (addr == WINDOW_ADDR) tracker.window = value[2:0];
      @(posedge clock);
      verify_window();
   endtask

   task automatic random_phase(input int send_pct, input int recv_pct, input int win,
                               input int count);
      drain();
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      set_csr(WINDOW_ADDR, win);
      repeat (count) send_packet(random_packet());
   endtask

   // -------------------------------------------------------------------------
   // main sequence
   // -------------------------------------------------------------------------
   initial begin
      packet_type pkt;
      int         slot;
      tracker = new();
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_seq_number   <= '0;
      req_ack_field    <= '0;
      req_check_value  <= '0;
      req_payload_low  <= '0;
      req_payload_mid  <= '0;
      req_payload_high <= '0;
      psel             <= 1'b0;
      penable          <= 1'b0;
      pwrite           <= 1'b0;
      paddr            <= '0;
      pwdata           <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      verify_window();   // reset value

      // --- directed: window 6, expected number 0 ---
      send_packet(make_packet(0, -1, '0, '0, '0));       // in order: ACK then delivery
      send_packet(make_packet(0, -128, '0, '0, '0));     // just behind window, checksum -128
      pkt = make_packet(1, -1, rnd64(), rnd64(), $urandom);
      pkt.check = ~pkt.check;                            // bad checksum: silently dropped
      send_packet(pkt);
      send_packet(make_packet(255, 127, '1, '1, '1));    // largest checksum, seq out of space
      send_packet(make_packet(SRR_SEQ_SPACE, -1, rnd64(), rnd64(), $urandom));
      pkt = make_packet(3, -1, rnd64(), rnd64(), $urandom);
      send_packet(pkt);                                  // out of order: buffered, one ACK
      send_packet(pkt);                                  // already buffered: two ACKs
      send_packet(make_packet(7, -1, rnd64(), rnd64(), $urandom));  // one past window edge
      send_packet(make_packet(1, 127, '1, '1, '1));
      send_packet(make_packet(2, -128, '0, '0, '0));     // also releases slot 3

      // widest window: fill six slots, then the gap packet releases them all
      drain();
      set_csr(WINDOW_ADDR, 7);
      for (slot = 5; slot <= 10; slot++)
         send_packet(make_packet(slot, -1, rnd64(), rnd64(), $urandom));
      send_packet(make_packet(4, $urandom_range(255), rnd64(), rnd64(), $urandom));

      // zero window takes nothing and re-acknowledges nothing
      drain();
      set_csr(WINDOW_ADDR, 0);
      send_packet(make_packet(11, -1, rnd64(), rnd64(), $urandom));
      send_packet(make_packet(10, -1, rnd64(), rnd64(), $urandom));

      // unmapped address must leave the window alone; then a one-packet window
      drain();
      set_csr(SPARE_ADDR, 3);
      set_csr(WINDOW_ADDR, 1);
      send_packet(make_packet(11, -1, rnd64(), rnd64(), $urandom));
      send_packet(make_packet(13, -1, rnd64(), rnd64(), $urandom));  // beyond window: drop
      send_packet(make_packet(11, -1, rnd64(), rnd64(), $urandom));  // old: re-ACK

      // --- random traffic: receiver idles, then sender idles, then neither ---
      random_phase(38, 77, 7, 46);
      random_phase(77, 38, $urandom_range(6, 1), 46);
      random_phase(0, 0, $urandom_range(7, 1), 46);
      drain();

      if (tracker.errors == 0 && tracker.pending() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
